// ----- design/rc4_pkg.sv -----
package rc4_pkg;

	localparam int PERM_DEPTH = 256;

	typedef logic [7:0] byte_t;

	// Codes of the kind field.
	localparam logic KIND_KEY = 1'b0;
	localparam logic KIND_GEN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEN_J,
		ST_GEN_A,
		ST_GEN_B,
		ST_KS_RD,
		ST_KS_J,
		ST_KS_WA,
		ST_KS_WB
	} state_t;

	// Request to the permutation memory: a read, a write and a clear.
	typedef struct packed {
		logic  re;
		byte_t raddr;
		logic  we;
		byte_t waddr;
		byte_t wdata;
		logic  clr;
	} perm_req_t;

endpackage

// ----- design/rc4_perm_ram.sv -----
module rc4_perm_ram
	import rc4_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  perm_req_t req,
	output byte_t     rdata
);

	byte_t                 mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] vld_q;
	byte_t                 rdata_q;
	byte_t                 raddr_q;
	logic                  rvld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
			raddr_q <= req.raddr;
		end
	end

	// An entry that has not been written since the last clear or reset reads as its own index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= vld_q[req.raddr] & ~req.clr;
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : raddr_q;

endmodule

// ----- design/rc4_key_ram.sv -----
module rc4_key_ram
	import rc4_pkg::*;
#(
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  byte_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output byte_t         rdata
);

	byte_t mem [DEPTH];
	byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/rc4_keystream_generator_top.sv -----
// Channel   Direction  Signals                                  Transfer
// input     in         in_valid, in_ready, kind, key_byte,      in_valid && in_ready
//                      key_last
// output    out        out_valid, out_ready, keystream_byte     out_valid && out_ready
//
// A key byte leaves the block idle and ready for the next item. A generate item runs
// through ST_GEN_J, ST_GEN_A and ST_GEN_B with in_ready low, and its result is
// registered as the block leaves ST_GEN_B. The single read port and single write port
// of the permutation memory set this order: three dependent reads (S[i], S[j], then
// the output entry), overlapped with the two writes of the swap. The last key byte starts
// the key schedule, 256 steps of ST_KS_RD to ST_KS_WB, during which in_ready is low.
// Reset restores the identity permutation at once through per-entry valid bits.
// A result that is not taken holds the next generate item in its last cycle.
module rc4_keystream_generator_top
	import rc4_pkg::*;
#(
	parameter int KEY_STORE_DEPTH = 256
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  kind,
	input  byte_t key_byte,
	input  logic  key_last,
	output logic  out_valid,
	input  logic  out_ready,
	output byte_t keystream_byte
);

	localparam int KA = $clog2(KEY_STORE_DEPTH);
	localparam int CW = $clog2(KEY_STORE_DEPTH + 1);

	state_t    state_q, state_nx;
	perm_req_t preq;
	byte_t     perm_rd;
	byte_t     key_rd;

	logic          key_we, key_re;
	logic [KA-1:0] key_waddr;

	byte_t         i_q, j_q, si_q, sj_q, t_q;
	byte_t         a_q, jj_q, sa_q;
	logic [KA-1:0] kpos_q;
	logic [CW-1:0] klen_q, kcnt_q;
	byte_t         ks_q;
	logic          out_valid_q;

	logic          accept, acc_key, acc_gen, key_fits, out_free;
	byte_t         jj_nx, j_nx, ks_nx;
	logic [CW-1:0] kpos_inc;

	assign accept   = in_valid && in_ready;
	assign acc_key  = accept && (kind == KIND_KEY);
	assign acc_gen  = accept && (kind == KIND_GEN);
	assign key_fits = kcnt_q < CW'(KEY_STORE_DEPTH);
	assign out_free = !out_valid_q || out_ready;
	assign jj_nx    = jj_q + perm_rd + key_rd;
	assign j_nx     = j_q + perm_rd;
	assign kpos_inc = CW'(kpos_q) + CW'(1);

	// After the swap S[j] holds the old S[i] and S[i] the old S[j].
	assign ks_nx = (t_q == j_q) ? si_q : ((t_q == i_q) ? sj_q : perm_rd);

	rc4_perm_ram u_perm (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (preq),
		.rdata (perm_rd)
	);

	rc4_key_ram #(
		.DEPTH(KEY_STORE_DEPTH)
	) u_key (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_byte),
		.re   (key_re),
		.raddr(kpos_q),
		.rdata(key_rd)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_gen) begin
					state_nx = ST_GEN_J;
				end else if (acc_key && key_last) begin
					state_nx = ST_KS_RD;
				end
			end
			ST_GEN_J: state_nx = ST_GEN_A;
			ST_GEN_A: state_nx = ST_GEN_B;
			ST_GEN_B: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_KS_RD: state_nx = ST_KS_J;
			ST_KS_J:  state_nx = ST_KS_WA;
			ST_KS_WA: state_nx = ST_KS_WB;
			ST_KS_WB: state_nx = (a_q == 8'hff) ? ST_IDLE : ST_KS_RD;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		preq      = '0;
		key_we    = 1'b0;
		key_waddr = kcnt_q[KA-1:0];
		key_re    = 1'b0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				preq.re    = acc_gen;
				preq.raddr = i_q + 8'd1;
				key_we     = acc_key && key_fits;
				preq.clr   = acc_key && key_last;
			end
			ST_GEN_J: begin
				preq.re    = 1'b1;
				preq.raddr = j_nx;
			end
			ST_GEN_A: begin
				preq.we    = 1'b1;
				preq.waddr = i_q;
				preq.wdata = perm_rd;
				preq.re    = 1'b1;
				preq.raddr = si_q + perm_rd;
			end
			ST_GEN_B: begin
				preq.we    = 1'b1;
				preq.waddr = j_q;
				preq.wdata = si_q;
			end
			ST_KS_RD: begin
				preq.re    = 1'b1;
				preq.raddr = a_q;
				key_re     = 1'b1;
			end
			ST_KS_J: begin
				preq.re    = 1'b1;
				preq.raddr = jj_nx;
			end
			ST_KS_WA: begin
				preq.we    = 1'b1;
				preq.waddr = a_q;
				preq.wdata = perm_rd;
			end
			ST_KS_WB: begin
				preq.we    = 1'b1;
				preq.waddr = jj_q;
				preq.wdata = sa_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			kcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_GEN_B && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_gen) begin
						i_q <= i_q + 8'd1;
					end
					if (acc_key) begin
						if (key_last) begin
							kcnt_q <= '0;
							i_q    <= '0;
							j_q    <= '0;
						end else if (key_fits) begin
							kcnt_q <= kcnt_q + CW'(1);
						end
					end
				end
				ST_GEN_J: j_q <= j_nx;
				default: begin
					i_q <= i_q;
				end
			endcase
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc_key && key_last) begin
					klen_q <= key_fits ? kcnt_q + CW'(1) : kcnt_q;
					a_q    <= '0;
					jj_q   <= '0;
					kpos_q <= '0;
				end
			end
			ST_GEN_J: si_q <= perm_rd;
			ST_GEN_A: begin
				sj_q <= perm_rd;
				t_q  <= si_q + perm_rd;
			end
			ST_GEN_B: begin
				if (out_free) begin
					ks_q <= ks_nx;
				end
			end
			ST_KS_J: begin
				jj_q <= jj_nx;
				sa_q <= perm_rd;
			end
			ST_KS_WB: begin
				a_q    <= a_q + 8'd1;
				kpos_q <= (kpos_inc >= klen_q) ? '0 : kpos_inc[KA-1:0];
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign keystream_byte = ks_q;

`ifndef NO_ASSERTIONS
	a_result_from_gen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_GEN_B)
		else $error("result appeared without a generate swap");

	a_no_accept_in_schedule: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KS_RD || state_q == ST_KS_J || state_q == ST_KS_WA ||
		 state_q == ST_KS_WB) |-> !in_ready)
		else $error("input taken during key schedule");

	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GEN_B |-> ($past(state_q) == ST_GEN_A || $past(state_q) == ST_GEN_B))
		else $error("second swap write out of order");

	a_key_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kcnt_q <= CW'(KEY_STORE_DEPTH))
		else $error("key count beyond store depth");
`endif

endmodule
